FILE: src/bstk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstk_pkg
// Shared types, sizes and codes for the bounded stack with a top-entry ALU.
// ----------------------------------------------------------------------------
package bstk_pkg;

    localparam int DEPTH   = 256;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int LIMIT_W = 9;
    localparam int WORD_W  = 32;
    localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_PEEK = 3'd2,
        OP_ADD  = 3'd3,
        OP_SUB  = 3'd4,
        OP_MUL  = 3'd5,
        OP_DIV  = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_DIVZERO = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic              start;
        alu_op_t           op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } alu_rsp_t;

endpackage

FILE: src/bstk_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstk_in_if
// Operation channel: opcode and operand word with valid/ready.
// ----------------------------------------------------------------------------
interface bstk_in_if import bstk_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [2:0]               op;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

FILE: src/bstk_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstk_out_if
// Result channel: data word and status code with valid/ready.
// ----------------------------------------------------------------------------
interface bstk_out_if import bstk_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] data;
    logic [1:0]               status;

    modport source (output valid, output data, output status, input ready);
    modport sink   (input valid, input data, input status, output ready);
endinterface

FILE: src/bstk_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstk_cfg_if
// Configuration write channel for the stack limit register.
// ----------------------------------------------------------------------------
interface bstk_cfg_if import bstk_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/bstk_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstk_alu
// Iterative ALU around one shared 33-bit adder: add/sub in one pass,
// shift-add multiply and restoring signed divide at one bit per cycle.
// ----------------------------------------------------------------------------
module bstk_alu import bstk_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    typedef enum logic [5:0] {
        A_IDLE   = 6'b000001,
        A_ADDSUB = 6'b000010,
        A_NEGA   = 6'b000100,
        A_NEGB   = 6'b001000,
        A_STEP   = 6'b010000,
        A_NEGQ   = 6'b100000
    } astate_t;

    astate_t           state_reg, state_next;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    alu_op_t           op_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] res_reg;
    logic              neg_reg;

    logic [WORD_W:0]   add_x;
    logic [WORD_W:0]   add_y;
    logic              add_sub;
    logic [WORD_W+1:0] sum;
    logic              ge;
    logic [WORD_W-1:0] rem_next;

    // Shared adder: x + y or x - y, carry out marks x >= y on subtract
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            A_ADDSUB:
            begin
                add_x   = {1'b0, a_reg};
                add_y   = {1'b0, b_reg};
                add_sub = (op_reg == ALU_SUB);
            end
            A_NEGA:
            begin
                add_y   = {1'b0, a_reg};
                add_sub = 1'b1;
            end
            A_NEGB:
            begin
                add_y   = {1'b0, b_reg};
                add_sub = 1'b1;
            end
            A_STEP:
            begin
                if (op_reg == ALU_MUL)
                begin
                    add_x = {1'b0, acc_reg};
                    add_y = {1'b0, a_reg};
                end
                else
                begin
                    add_x   = {acc_reg, a_reg[WORD_W-1]};
                    add_y   = {1'b0, b_reg};
                    add_sub = 1'b1;
                end
            end
            A_NEGQ:
            begin
                add_y   = {1'b0, a_reg};
                add_sub = 1'b1;
            end
            default:
            begin
                add_x = '0;
            end
        endcase
        sum      = {1'b0, add_x} + {1'b0, add_y ^ {(WORD_W+1){add_sub}}}
                   + {{(WORD_W+1){1'b0}}, add_sub};
        ge       = sum[WORD_W+1];
        rem_next = ge ? sum[WORD_W-1:0] : {acc_reg[WORD_W-2:0], a_reg[WORD_W-1]};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    unique case (req.op) inside
                        ALU_ADD, ALU_SUB: state_next = A_ADDSUB;
                        ALU_MUL:          state_next = A_STEP;
                        default:          state_next = A_NEGA;
                    endcase
                end
            end
            A_ADDSUB: state_next = A_IDLE;
            A_NEGA:   state_next = A_NEGB;
            A_NEGB:   state_next = A_STEP;
            A_STEP:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = (op_reg == ALU_MUL) ? A_IDLE : A_NEGQ;
                end
            end
            A_NEGQ:   state_next = A_IDLE;
            default:  state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg != A_IDLE) && (state_next == A_IDLE);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            A_IDLE:
            begin
                op_reg  <= req.op;
                a_reg   <= req.a;
                b_reg   <= req.b;
                acc_reg <= '0;
                cnt_reg <= '1;
            end
            A_ADDSUB:
            begin
                res_reg <= sum[WORD_W-1:0];
            end
            A_NEGA:
            begin
                neg_reg <= a_reg[WORD_W-1] ^ b_reg[WORD_W-1];
                if (a_reg[WORD_W-1])
                begin
                    a_reg <= sum[WORD_W-1:0];
                end
            end
            A_NEGB:
            begin
                if (b_reg[WORD_W-1])
                begin
                    b_reg <= sum[WORD_W-1:0];
                end
            end
            A_STEP:
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (op_reg == ALU_MUL)
                begin
                    // Add the shifted multiplicand where the multiplier bit is set
                    if (b_reg[0])
                    begin
                        acc_reg <= sum[WORD_W-1:0];
                    end
                    a_reg   <= {a_reg[WORD_W-2:0], 1'b0};
                    b_reg   <= {1'b0, b_reg[WORD_W-1:1]};
                    res_reg <= b_reg[0] ? sum[WORD_W-1:0] : acc_reg;
                end
                else
                begin
                    // Shift the quotient bit into the dividend register
                    acc_reg <= rem_next;
                    a_reg   <= {a_reg[WORD_W-2:0], ge};
                end
            end
            A_NEGQ:
            begin
                res_reg <= neg_reg ? sum[WORD_W-1:0] : a_reg;
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

FILE: src/bounded_stack_with_top_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_stack_with_top_alu
// Bounded LIFO of signed words with an iterative ALU on the top entry.
// One item in flight; the next item is accepted in the cycle after the result beat.
// Multiply and divide run 32 iterations of the shared adder in bstk_alu;
//   add and subtract take one pass.
// Reset: entry count cleared (empty), stack limit set to 256; storage is
//   not cleared, and only entries below the count are ever used.
// ----------------------------------------------------------------------------
module bounded_stack_with_top_alu import bstk_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bstk_in_if.sink      req,
    bstk_out_if.source   rsp,
    bstk_cfg_if.sink     cfg
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_ALU    = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [LIMIT_W-1:0]  limit_reg;
    op_t                 op_reg;
    logic [WORD_W-1:0]   value_reg;
    logic [WORD_W-1:0]   data_reg, data_next;
    status_t             status_reg, status_next;
    logic [WORD_W-1:0]   rd_data_reg;
    logic [WORD_W-1:0]   mem [DEPTH];

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic [ADDR_W-1:0]   top_idx;
    logic [CNT_W-1:0]    count_dec;
    logic [CMP_W-1:0]    lim_c;
    logic [CMP_W-1:0]    cap_c;
    logic                full;
    logic                empty;
    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;

    bstk_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign count_dec = count_reg - CNT_W'(1);
    assign top_idx   = count_dec[ADDR_W-1:0];
    assign lim_c     = CMP_W'(limit_reg);
    assign cap_c     = (lim_c > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : lim_c;
    assign full      = (CMP_W'(count_reg) >= cap_c);
    assign empty     = (count_reg == '0);

    assign req.ready  = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign rsp.valid  = (state_reg == S_OUT);
    assign rsp.data   = data_reg;
    assign rsp.status = status_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        data_next     = data_reg;
        status_next   = status_reg;
        wr_en         = 1'b0;
        wr_addr       = top_idx;
        wr_data       = alu_rsp.result;
        alu_req.start = 1'b0;
        alu_req.a     = rd_data_reg;
        alu_req.b     = value_reg;
        unique case (op_reg)
            OP_ADD:  alu_req.op = ALU_ADD;
            OP_SUB:  alu_req.op = ALU_SUB;
            OP_MUL:  alu_req.op = ALU_MUL;
            default: alu_req.op = ALU_DIV;
        endcase

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next  = S_OUT;
                status_next = ST_OK;
                if (op_reg == OP_PUSH)
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                        data_next   = empty ? '1 : rd_data_reg;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[ADDR_W-1:0];
                        wr_data    = value_reg;
                        count_next = count_reg + CNT_W'(1);
                        data_next  = value_reg;
                    end
                end
                else if (empty)
                begin
                    status_next = ST_EMPTY;
                    data_next   = '1;
                end
                else
                begin
                    unique case (op_reg) inside
                        OP_POP:
                        begin
                            data_next  = rd_data_reg;
                            count_next = count_dec;
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                        begin
                            if ((op_reg == OP_DIV) && (value_reg == '0))
                            begin
                                status_next = ST_DIVZERO;
                                data_next   = rd_data_reg;
                            end
                            else
                            begin
                                alu_req.start = 1'b1;
                                state_next    = S_ALU;
                            end
                        end
                        default:
                        begin
                            // Peek and the spare opcode
                            data_next = rd_data_reg;
                        end
                    endcase
                end
            end
            S_ALU:
            begin
                if (alu_rsp.done)
                begin
                    wr_en      = 1'b1;
                    data_next  = alu_rsp.result;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg.valid && cfg.ready)
            begin
                limit_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        status_reg <= status_next;
        // Hold the beat while the block works on it
        if (req.valid && req.ready)
        begin
            op_reg    <= op_t'(req.op);
            value_reg <= req.value;
        end
    end

    // Stack storage, read data registered at the current top
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[top_idx];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(DEPTH))
        else $error("entry count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) && (op_reg == OP_PUSH) && !full
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("accepted push did not grow the stack");

    a_alu_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> (state_reg == S_ALU))
        else $error("ALU finished outside of an arithmetic item");

    a_empty_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_EMPTY) |-> (rsp.data == '1))
        else $error("empty status without all-ones data");

endmodule
